@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL modules of the key click event detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define KCED_ASSERT_ON(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The expression must never be true at a rising clock edge outside reset.
`define KCED_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ rtl/kced_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package kced_pkg;

   localparam int PIN_W      = 4;
   localparam int KEY_W      = 2;
   localparam int FLAG_W     = 7;
   localparam int TIMER_W    = 16;
   localparam int PERIOD_W   = 8;
   localparam int SNAP_W     = 28;
   localparam int SNAP_KEYS  = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Command codes.
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_CHECK = 1'b1;

   // Flag bit positions.
   localparam int FLG_HOLD   = 0;
   localparam int FLG_DOWN   = 1;
   localparam int FLG_UP     = 2;
   localparam int FLG_SINGLE = 3;
   localparam int FLG_DOUBLE = 4;
   localparam int FLG_LONG   = 5;
   localparam int FLG_REPEAT = 6;

   localparam logic [FLAG_W-1:0] HOLD_ONLY_MASK = 7'h01;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_PERIOD    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_TICKS       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT_TICKS     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DOUBLE_TICKS     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_HIGH_MASK = 3'd4;

   // Configuration reset values.
   localparam logic [PERIOD_W-1:0] RST_SAMPLE_PERIOD    = 8'd20;
   localparam logic [TIMER_W-1:0]  RST_LONG_TICKS       = 16'd600;
   localparam logic [TIMER_W-1:0]  RST_REPEAT_TICKS     = 16'd80;
   localparam logic [TIMER_W-1:0]  RST_DOUBLE_TICKS     = 16'd0;
   localparam logic [PIN_W-1:0]    RST_ACTIVE_HIGH_MASK = 4'd4;

   // Classified request, handed from the front end to the back end.
   typedef struct packed {
      logic              is_tick;
      logic [PIN_W-1:0]  pins;
      logic              key_ok;
      logic [KEY_W-1:0]  key;
      logic [FLAG_W-1:0] mask;
      logic              clear_ok;
   } cmd_type;

   // One result.
   typedef struct packed {
      logic              hit;
      logic [SNAP_W-1:0] snapshot;
   } res_type;

endpackage
`default_nettype wire

@@ rtl/kced_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module kced_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             wr_en, rd_en;

   assign full     = (count_ff == CntW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign wr_en    = push && !full;
   assign rd_en    = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + CntW'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `KCED_ASSERT_NEVER(a_fifo_no_overflow, clock, reset, count_ff > CntW'(DEPTH), "fifo count over depth")
   `KCED_ASSERT_ON(a_fifo_count_up, clock, reset, (wr_en && !rd_en) |=> (count_ff == $past(count_ff) + CntW'(1)), "fifo count did not grow on write")

endmodule
`default_nettype wire

@@ rtl/kced_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module kced_front import kced_pkg::*; #(
   parameter int KEYS = 4
) (
   input  wire logic              req_push,
   input  wire logic              req_command,
   input  wire logic [PIN_W-1:0]  req_pin_levels,
   input  wire logic [KEY_W-1:0]  req_key_index,
   input  wire logic [FLAG_W-1:0] req_flag_mask,
   input  wire logic              cmd_full,
   output logic                   cmd_push,
   output cmd_type                cmd_data
);

   // Decode the request into what the back end needs: tick or check, whether the
   // key exists, and whether a hit may clear the masked flags.
   always_comb begin
      cmd_data.is_tick  = (req_command == CMD_TICK);
      cmd_data.pins     = req_pin_levels;
      cmd_data.key_ok   = (int'(req_key_index) < KEYS);
      cmd_data.key      = req_key_index;
      cmd_data.mask     = req_flag_mask;
      cmd_data.clear_ok = (req_flag_mask != HOLD_ONLY_MASK);
   end

   assign cmd_push = req_push && !cmd_full;

endmodule
`default_nettype wire

@@ rtl/kced_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module kced_back import kced_pkg::*; #(
   parameter int KEYS = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  cmd_empty,
   input  wire cmd_type               cmd_data,
   output logic                       cmd_pop,
   input  wire logic                  res_full,
   output logic                       res_push,
   output res_type                    res_data
);

   typedef enum logic [2:0] {
      CS_IDLE    = 3'd0,
      CS_PRESSED = 3'd1,
      CS_WAIT    = 3'd2,
      CS_SECOND  = 3'd3,
      CS_LONG    = 3'd4
   } click_state_type;

   localparam int NSnap = (KEYS < SNAP_KEYS) ? KEYS : SNAP_KEYS;

   // Configuration registers.
   logic [PERIOD_W-1:0] sample_period_ff;
   logic [TIMER_W-1:0]  long_ticks_ff;
   logic [TIMER_W-1:0]  repeat_ticks_ff;
   logic [TIMER_W-1:0]  double_ticks_ff;
   logic [PIN_W-1:0]    active_high_ff;

   // Key state.
   logic [PERIOD_W-1:0]                sample_count_ff, sample_count_in;
   logic [KEYS-1:0]                    level_ff, level_in;
   click_state_type [KEYS-1:0]         click_state_ff, click_state_in;
   logic [KEYS-1:0][TIMER_W-1:0]       hold_timer_ff, hold_timer_in;
   logic [KEYS-1:0][FLAG_W-1:0]        flags_ff, flags_in;

   logic                sample_now;
   logic [PERIOD_W-1:0] count_inc;
   logic [7:0]          pins_ext;
   logic [7:0]          pol_ext;
   logic                hit;

   assign cmd_pop  = !cmd_empty && !res_full;
   assign res_push = cmd_pop;

   assign count_inc  = sample_count_ff + PERIOD_W'(1);
   assign sample_now = (count_inc >= sample_period_ff);
   assign pins_ext   = {{(8 - PIN_W){1'b0}}, cmd_data.pins};
   assign pol_ext    = {{(8 - PIN_W){1'b0}}, active_high_ff};

   always_comb begin
      logic [TIMER_W-1:0] t;
      logic [FLAG_W-1:0]  f;
      logic               cur;
      logic               prev;
      logic               sel;

      sample_count_in = sample_count_ff;
      level_in        = level_ff;
      click_state_in  = click_state_ff;
      hold_timer_in   = hold_timer_ff;
      flags_in        = flags_ff;
      hit             = 1'b0;

      if (cmd_pop && cmd_data.is_tick) begin
         sample_count_in = sample_now ? '0 : count_inc;
      end

      for (int k = 0; k < KEYS; k++) begin
         t    = hold_timer_ff[k] - TIMER_W'(hold_timer_ff[k] != '0);
         f    = flags_ff[k];
         cur  = (pins_ext[k[2:0]] == pol_ext[k[2:0]]);
         prev = level_ff[k];
         sel  = cmd_data.key_ok && (int'(cmd_data.key) == k);

         if (cmd_pop && cmd_data.is_tick) begin
            hold_timer_in[k] = t;
            if (sample_now) begin
               level_in[k] = cur;
               f[FLG_HOLD] = cur;
               if (cur && !prev) begin
                  f[FLG_DOWN] = 1'b1;
               end
               if (!cur && prev) begin
                  f[FLG_UP] = 1'b1;
               end
               unique case (click_state_ff[k])
                  CS_IDLE: begin
                     if (cur) begin
                        hold_timer_in[k]  = long_ticks_ff;
                        click_state_in[k] = CS_PRESSED;
                     end
                  end
                  CS_PRESSED: begin
                     if (!cur) begin
                        hold_timer_in[k]  = double_ticks_ff;
                        click_state_in[k] = CS_WAIT;
                     end else if (t == '0) begin
                        hold_timer_in[k]  = repeat_ticks_ff;
                        f[FLG_LONG]       = 1'b1;
                        click_state_in[k] = CS_LONG;
                     end
                  end
                  CS_WAIT: begin
                     if (cur) begin
                        f[FLG_DOUBLE]     = 1'b1;
                        click_state_in[k] = CS_SECOND;
                     end else if (t == '0) begin
                        f[FLG_SINGLE]     = 1'b1;
                        click_state_in[k] = CS_IDLE;
                     end
                  end
                  CS_SECOND: begin
                     if (!cur) begin
                        click_state_in[k] = CS_IDLE;
                     end
                  end
                  CS_LONG: begin
                     if (!cur) begin
                        click_state_in[k] = CS_IDLE;
                     end else if (t == '0) begin
                        hold_timer_in[k] = repeat_ticks_ff;
                        f[FLG_REPEAT]    = 1'b1;
                     end
                  end
                  default: begin
                     click_state_in[k] = CS_IDLE;
                  end
               endcase
               flags_in[k] = f;
            end
         end else if (cmd_pop && sel) begin
            if ((flags_ff[k] & cmd_data.mask) != '0) begin
               hit = 1'b1;
               if (cmd_data.clear_ok) begin
                  flags_in[k] = flags_ff[k] & ~cmd_data.mask;
               end
            end
         end
      end
   end

   always_comb begin
      res_data.hit      = hit;
      res_data.snapshot = '0;
      for (int k = 0; k < NSnap; k++) begin
         res_data.snapshot[FLAG_W*k +: FLAG_W] = flags_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_period_ff <= RST_SAMPLE_PERIOD;
         long_ticks_ff    <= RST_LONG_TICKS;
         repeat_ticks_ff  <= RST_REPEAT_TICKS;
         double_ticks_ff  <= RST_DOUBLE_TICKS;
         active_high_ff   <= RST_ACTIVE_HIGH_MASK;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_SAMPLE_PERIOD:    sample_period_ff <= csr_wdata[PERIOD_W-1:0];
            REG_LONG_TICKS:       long_ticks_ff    <= csr_wdata;
            REG_REPEAT_TICKS:     repeat_ticks_ff  <= csr_wdata;
            REG_DOUBLE_TICKS:     double_ticks_ff  <= csr_wdata;
            REG_ACTIVE_HIGH_MASK: active_high_ff   <= csr_wdata[PIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= '0;
         level_ff        <= '0;
         for (int k = 0; k < KEYS; k++) begin
            click_state_ff[k] <= CS_IDLE;
         end
         hold_timer_ff   <= '0;
         flags_ff        <= '0;
      end else begin
         sample_count_ff <= sample_count_in;
         level_ff        <= level_in;
         click_state_ff  <= click_state_in;
         hold_timer_ff   <= hold_timer_in;
         flags_ff        <= flags_in;
      end
   end

   `KCED_ASSERT_ON(a_check_keeps_timing, clock, reset, (cmd_pop && !cmd_data.is_tick) |=> ($stable(click_state_ff) && $stable(hold_timer_ff) && $stable(sample_count_ff)), "check request changed key timing state")
   `KCED_ASSERT_ON(a_idle_keeps_flags, clock, reset, !cmd_pop |=> $stable(flags_ff), "flags changed without a request")
   `KCED_ASSERT_ON(a_no_sample_keeps_state, clock, reset, (cmd_pop && cmd_data.is_tick && !sample_now) |=> ($stable(click_state_ff) && $stable(flags_ff)), "click state moved between samples")

endmodule
`default_nettype wire

@@ rtl/key_click_event_detector_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Ports                                              | Direction
// ----------+----------------------------------------------------+----------
// request   | req_push, req_full, req_command, req_pin_levels,   | in
//           | req_key_index, req_flag_mask                       |
// response  | rsp_empty, rsp_pop, rsp_check_hit, rsp_flags_snapshot | out
// config    | csr_valid, csr_ready, csr_index, csr_wdata         | in
//
// One request per clock is sustained: the back end retires one request from the
// request queue each cycle that the response queue has room.
// A request accepted into the request queue is executed by the back end when it
// leaves that queue, and its response is registered in the response queue, from
// where it can be popped.
// Reset is synchronous and active high; it restores the register defaults and
// clears all key state at once, with no clearing pass.
// req_full rises only when the request queue is full, which happens only when
// responses back up because rsp_pop stays low.
module key_click_event_detector_unit import kced_pkg::*; #(
   parameter int KEYS = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic                  req_command,
   input  wire logic [PIN_W-1:0]      req_pin_levels,
   input  wire logic [KEY_W-1:0]      req_key_index,
   input  wire logic [FLAG_W-1:0]     req_flag_mask,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output logic                       rsp_check_hit,
   output logic [SNAP_W-1:0]          rsp_flags_snapshot,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type cmd_in;
   cmd_type cmd_out;
   res_type res_in;
   res_type res_out;
   logic    cmd_push;
   logic    cmd_full;
   logic    cmd_empty;
   logic    cmd_pop;
   logic    res_push;
   logic    res_full;

   // Writes always go in unchecked; software must only write while the block is idle.
   assign csr_ready = 1'b1;
   assign req_full  = cmd_full;

   // The front end classifies each request and drops it into a short queue.
   kced_front #(
      .KEYS (KEYS)
   ) u_front (
      .req_push       (req_push),
      .req_command    (req_command),
      .req_pin_levels (req_pin_levels),
      .req_key_index  (req_key_index),
      .req_flag_mask  (req_flag_mask),
      .cmd_full       (cmd_full),
      .cmd_push       (cmd_push),
      .cmd_data       (cmd_in)
   );

   kced_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (2)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .empty     (cmd_empty)
   );

   // The back end holds the configuration and per-key state and executes requests.
   kced_back #(
      .KEYS (KEYS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_out),
      .cmd_pop   (cmd_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res_data  (res_in)
   );

   // Responses wait here so a stalled consumer never blocks new requests at once.
   kced_fifo #(
      .WIDTH ($bits(res_type)),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_in),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (res_out),
      .empty     (rsp_empty)
   );

   assign rsp_check_hit      = res_out.hit;
   assign rsp_flags_snapshot = res_out.snapshot;

endmodule
`default_nettype wire

@@ dv/kced_checker.sv @@
`timescale 1ns / 1ps
module kced_checker import kced_pkg::*; #(
   parameter int KEYS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic                  req_full,
   input  logic                  req_command,
   input  logic [PIN_W-1:0]      req_pin_levels,
   input  logic [KEY_W-1:0]      req_key_index,
   input  logic [FLAG_W-1:0]     req_flag_mask,
   input  logic                  rsp_empty,
   input  logic                  rsp_pop,
   input  logic                  rsp_check_hit,
   input  logic [SNAP_W-1:0]     rsp_flags_snapshot,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    outstanding_reports
);

   typedef enum logic [2:0] {
      CLICK_IDLE,
      CLICK_PRESSED,
      CLICK_WAIT,
      CLICK_SECOND,
      CLICK_LONG
   } click_e;

   logic [PERIOD_W-1:0] cfg_period;
   logic [TIMER_W-1:0]  cfg_long;
   logic [TIMER_W-1:0]  cfg_repeat;
   logic [TIMER_W-1:0]  cfg_double;
   logic [PIN_W-1:0]    cfg_polarity;

   logic [PERIOD_W-1:0] tick_count;
   logic                key_level [KEYS];
   click_e              key_click [KEYS];
   logic [TIMER_W-1:0]  key_timer [KEYS];
   logic [FLAG_W-1:0]   key_flags [KEYS];

   // Expected hit bit and flag snapshot, oldest request first.
   res_type flag_reports [$];

   task automatic report_mismatch(input string what, input logic [SNAP_W-1:0] got,
                                  input logic [SNAP_W-1:0] want);
      $display("%0t kced_checker: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      res_type            want;
      logic               cur;
      logic               prev;
      logic [FLAG_W-1:0]  flags;
      if (reset) begin
         cfg_period   = RST_SAMPLE_PERIOD;
         cfg_long     = RST_LONG_TICKS;
         cfg_repeat   = RST_REPEAT_TICKS;
         cfg_double   = RST_DOUBLE_TICKS;
         cfg_polarity = RST_ACTIVE_HIGH_MASK;
         tick_count   = '0;
         for (int k = 0; k < KEYS; k++) begin
            key_level[k] = 1'b0;
            key_click[k] = CLICK_IDLE;
            key_timer[k] = '0;
            key_flags[k] = '0;
         end
         flag_reports.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (flag_reports.size() == 0) begin
               report_mismatch("response with nothing expected", rsp_flags_snapshot, '0);
            end else begin
               want = flag_reports.pop_front();
               if (rsp_check_hit !== want.hit)
                  report_mismatch("check_hit", SNAP_W'(rsp_check_hit), SNAP_W'(want.hit));
               if (rsp_flags_snapshot !== want.snapshot)
                  report_mismatch("flags_snapshot", rsp_flags_snapshot, want.snapshot);
            end
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SAMPLE_PERIOD:    cfg_period   = csr_wdata[PERIOD_W-1:0];
               REG_LONG_TICKS:       cfg_long     = csr_wdata[TIMER_W-1:0];
               REG_REPEAT_TICKS:     cfg_repeat   = csr_wdata[TIMER_W-1:0];
               REG_DOUBLE_TICKS:     cfg_double   = csr_wdata[TIMER_W-1:0];
               REG_ACTIVE_HIGH_MASK: cfg_polarity = csr_wdata[PIN_W-1:0];
               default: ;
            endcase
         end

         if (req_push && !req_full) begin
            want = '0;
            if (req_command == CMD_TICK) begin
               for (int k = 0; k < KEYS; k++)
                  if (key_timer[k] != '0) key_timer[k] = key_timer[k] - TIMER_W'(1);
               tick_count = tick_count + PERIOD_W'(1);
               if (tick_count >= cfg_period) begin
                  tick_count = '0;
                  for (int k = 0; k < KEYS; k++) begin
                     cur   = (req_pin_levels[k] == cfg_polarity[k]);
                     prev  = key_level[k];
                     flags = key_flags[k];
                     key_level[k] = cur;
                     flags[FLG_HOLD] = cur;
                     if (cur && !prev) flags[FLG_DOWN] = 1'b1;
                     if (!cur && prev) flags[FLG_UP] = 1'b1;
                     case (key_click[k])
                        CLICK_IDLE: begin
                           if (cur) begin
                              key_timer[k] = cfg_long;
                              key_click[k] = CLICK_PRESSED;
                           end
                        end
                        CLICK_PRESSED: begin
                           if (!cur) begin
                              key_timer[k] = cfg_double;
                              key_click[k] = CLICK_WAIT;
                           end else if (key_timer[k] == '0) begin
                              key_timer[k] = cfg_repeat;
                              flags[FLG_LONG] = 1'b1;
                              key_click[k] = CLICK_LONG;
                           end
                        end
                        CLICK_WAIT: begin
                           if (cur) begin
                              flags[FLG_DOUBLE] = 1'b1;
                              key_click[k] = CLICK_SECOND;
                           end else if (key_timer[k] == '0) begin
                              flags[FLG_SINGLE] = 1'b1;
                              key_click[k] = CLICK_IDLE;
                           end
                        end
                        CLICK_SECOND: begin
                           if (!cur) key_click[k] = CLICK_IDLE;
                        end
                        CLICK_LONG: begin
                           if (!cur) begin
                              key_click[k] = CLICK_IDLE;
                           end else if (key_timer[k] == '0) begin
                              key_timer[k] = cfg_repeat;
                              flags[FLG_REPEAT] = 1'b1;
                           end
                        end
                        default: key_click[k] = CLICK_IDLE;
                     endcase
                     key_flags[k] = flags;
                  end
               end
            end else if (req_key_index < KEYS &&
                         (key_flags[req_key_index] & req_flag_mask) != '0) begin
               // A hold-only test leaves the hold bit standing.
               if (req_flag_mask != HOLD_ONLY_MASK)
                  key_flags[req_key_index] = key_flags[req_key_index] & ~req_flag_mask;
               want.hit = 1'b1;
            end
            for (int k = 0; k < SNAP_KEYS; k++)
               if (k < KEYS) want.snapshot[FLAG_W*k +: FLAG_W] = key_flags[k];
            flag_reports.push_back(want);
         end
      end
      outstanding_reports = flag_reports.size();
   end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
   import kced_pkg::*;

   localparam int KEYS = 4;
   // Cycles without any accepted request, response or register write before giving up.
   localparam int STALL_LIMIT = 2000;
   // Length of the deliberate response hold-off that backs up the block.
   localparam int HOLD_OFF_CYCLES = 60;
   // Quiet cycles after the last response, so that the pipeline has gone quiet.
   localparam int DRAIN_CYCLES = 8;
   // An index past the register list; the block must ignore writes to it.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd5;

   logic                  clock;
   logic                  reset          = 1'b1;
   logic                  req_push       = 1'b0;
   logic                  req_full;
   logic                  req_command    = CMD_TICK;
   logic [PIN_W-1:0]      req_pin_levels = '0;
   logic [KEY_W-1:0]      req_key_index  = '0;
   logic [FLAG_W-1:0]     req_flag_mask  = '0;
   logic                  rsp_empty;
   logic                  rsp_pop        = 1'b0;
   logic                  rsp_check_hit;
   logic [SNAP_W-1:0]     rsp_flags_snapshot;
   logic                  csr_valid      = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index      = '0;
   logic [CSR_DATA_W-1:0] csr_wdata      = '0;

   int mismatch_count;
   int outstanding_reports;

   // Idle rates in percent for the request side and the response side.
   int send_idle_pct;
   int recv_idle_pct;

   // The stimulus asks for a hold-off by bumping hold_off_asked; the response
   // side serves each ask once and counts the stretch down itself.
   int hold_off_asked;
   int hold_off_done;
   int hold_off_left;

   int quiet_cycles;

   // Stimulus-side view of each key: whether the finger is down, and how many
   // more ticks it stays that way. The polarity mirrors the last register write
   // so that pin levels can be built from pressed/released intent.
   logic [PIN_W-1:0] polarity = RST_ACTIVE_HIGH_MASK;
   bit               finger_down [KEYS];
   int               run_left [KEYS];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   key_click_event_detector_unit #(.KEYS(KEYS)) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_command        (req_command),
      .req_pin_levels     (req_pin_levels),
      .req_key_index      (req_key_index),
      .req_flag_mask      (req_flag_mask),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_check_hit      (rsp_check_hit),
      .rsp_flags_snapshot (rsp_flags_snapshot),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   kced_checker #(.KEYS(KEYS)) u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_command         (req_command),
      .req_pin_levels      (req_pin_levels),
      .req_key_index       (req_key_index),
      .req_flag_mask       (req_flag_mask),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_check_hit       (rsp_check_hit),
      .rsp_flags_snapshot  (rsp_flags_snapshot),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .mismatch_count      (mismatch_count),
      .outstanding_reports (outstanding_reports)
   );

   // Response side. Outside a hold-off, pop is raised at random according to
   // the current idle rate. During a hold-off pop stays low for the whole
   // stretch while the request side keeps pushing, so the response queue and
   // then the request queue fill and req_full must rise.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_off_left > 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_pop <= 1'b0;
      end else if (hold_off_done != hold_off_asked) begin
         hold_off_done = hold_off_done + 1;
         hold_off_left = HOLD_OFF_CYCLES;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: any accepted request, response or register write restarts the count.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one request, with random idle cycles first, and returns at the edge
   // that accepts it. Push is left high so back-to-back requests need no
   // deassertion; req_full is read right after the edge, which is its value at
   // that edge.
   task automatic send_request(input logic cmd, input logic [PIN_W-1:0] pins,
                               input logic [KEY_W-1:0] key, input logic [FLAG_W-1:0] mask);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push       <= 1'b1;
      req_command    <= cmd;
      req_pin_levels <= pins;
      req_key_index  <= key;
      req_flag_mask  <= mask;
      do @(posedge clock); while (req_full);
   endtask

   // Valid is left high on return; the caller lowers it.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Stops offering, waits until every expected response has been popped and
   // then lets the pipeline go quiet. The first edge makes sure the checker has
   // seen the request accepted at the edge we returned on.
   task automatic settle();
      req_push  <= 1'b0;
      csr_valid <= 1'b0;
      @(posedge clock);
      while (outstanding_reports != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] period,
                             input logic [CSR_DATA_W-1:0] long_hold,
                             input logic [CSR_DATA_W-1:0] repeat_gap,
                             input logic [CSR_DATA_W-1:0] double_gap,
                             input logic [CSR_DATA_W-1:0] active_high);
      settle();
      write_reg(REG_SAMPLE_PERIOD, period);
      write_reg(REG_LONG_TICKS, long_hold);
      write_reg(REG_REPEAT_TICKS, repeat_gap);
      write_reg(REG_DOUBLE_TICKS, double_gap);
      write_reg(REG_ACTIVE_HIGH_MASK, active_high);
      csr_valid <= 1'b0;
      polarity = active_high[PIN_W-1:0];
   endtask

   // Random traffic. Most tick requests carry clean press/release patterns per
   // key, with hold times spread from a single tick up to dur_max so that
   // clicks, double clicks, long presses and repeats all occur. A few ticks carry
   // random pin noise. About a quarter of the requests are flag checks, mostly
   // with single-bit masks so that individual events get consumed.
   task automatic random_run(input int count, input int dur_max);
      logic [PIN_W-1:0]  pins;
      logic [FLAG_W-1:0] mask;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 25) begin
            case ($urandom_range(4))
               0, 1:    mask = 7'h01 << $urandom_range(FLAG_W - 1);
               2:       mask = HOLD_ONLY_MASK;
               3:       mask = FLAG_W'($urandom);
               default: mask = ($urandom_range(3) == 0) ? '0 : 7'h7F;
            endcase
            send_request(CMD_CHECK, PIN_W'($urandom), KEY_W'($urandom_range(KEYS - 1)), mask);
         end else begin
            for (int k = 0; k < KEYS; k++) begin
               if (run_left[k] == 0) begin
                  finger_down[k] = !finger_down[k];
                  run_left[k] = int'($urandom_range(dur_max, 1));
               end
               run_left[k] = run_left[k] - 1;
               pins[k] = finger_down[k] ? polarity[k] : !polarity[k];
            end
            if ($urandom_range(99) < 6) pins = PIN_W'($urandom);
            send_request(CMD_TICK, pins, KEY_W'($urandom), FLAG_W'($urandom));
         end
      end
   endtask

   initial begin
      send_idle_pct = 31;
      recv_idle_pct = 81;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset register values (sample every 20 ticks,
      // only key 2 active high). An empty mask and a full mask on clear flags
      // must both miss.
      send_request(CMD_CHECK, 4'h0, 2'd0, 7'h00);
      send_request(CMD_CHECK, 4'hF, 2'd3, 7'h7F);
      // Nineteen ticks of arbitrary pins, then a sampling tick with all pins
      // low: keys 0, 1 and 3 read as pressed and get hold and down flags.
      for (int i = 0; i < 20; i++)
         send_request(CMD_TICK, (i == 19) ? 4'h0 : 4'($urandom), KEY_W'($urandom),
                      FLAG_W'($urandom));
      // A hold-only test hits without clearing; the down test then clears.
      send_request(CMD_CHECK, 4'h0, 2'd0, HOLD_ONLY_MASK);
      send_request(CMD_CHECK, 4'h0, 2'd0, 7'h01 << FLG_DOWN);
      // Any other mask clears the hold bit along with the rest.
      send_request(CMD_CHECK, 4'h0, 2'd1, 7'h7F);

      // Fast sampling with short timers.
      set_config(16'd1, 16'd6, 16'd2, 16'd3, 16'hA);
      random_run(450, 20);

      // Every register at zero: sampling on each tick, long and repeat firing
      // on the very next sample, all keys active low.
      set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      random_run(250, 8);

      send_idle_pct = 81;
      recv_idle_pct = 31;
      settle();
      write_reg(REG_UNUSED, 16'hFFFF);
      set_config(16'd2, 16'd10, 16'd3, 16'd5, 16'hF);
      random_run(400, 30);

      // Upper extremes; all data bits high, the period register keeps its low byte.
      set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_run(300, 600);

      // No idling on either side, starting with a long response hold-off.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_config(16'd3, 16'd4, 16'd1, 16'd2, CSR_DATA_W'($urandom));
      hold_off_asked = hold_off_asked + 1;
      random_run(400, 20);

      set_config(16'd1, 16'd16, 16'd0, 16'd1, 16'h6);
      random_run(200, 40);

      settle();
      if (mismatch_count == 0 && outstanding_reports == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/kced_pkg.sv
rtl/kced_fifo.sv
rtl/kced_front.sv
rtl/kced_back.sv
rtl/key_click_event_detector_unit.sv
dv/kced_checker.sv
dv/tb_top.sv
